// ----- design/trial_division_factorizer_top_macros.svh -----
// Assertion macros shared by the factorizer checker.
`ifndef TRIAL_DIVISION_FACTORIZER_TOP_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("factorizer check failed");

// Next-cycle implication, disabled while reset is held.
`define TDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("factorizer check failed");

`endif

// ----- design/tdf_pkg.sv -----
// Shared constants and types for the trial-division factorizer.
package tdf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TWO  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_TEST = 4'b1000
  } tdf_state_t;

endpackage

// ----- design/trial_division_factorizer_top.sv -----
// The result for 0, 1 or a factor of two is formed in ST_TWO and registered once the output
// register is free. Each odd trial divisor costs one pass of the shared bit-serial divider.
// The worst case is a prime near 2^VALUE_WIDTH; one item is in work at a time.
// Synchronous active-low reset clears the sequencer, divider control and output valid.
// The next item is taken while the last result still waits in the output register.
module trial_division_factorizer_top #(
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_factor,
  output logic                   out_last,
  output logic                   out_no_factors
);

  import tdf_pkg::*;

  tdf_state_t             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] n_r, n_nxt;
  logic [VALUE_WIDTH-1:0] d_r, d_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] factor_r, factor_nxt;
  logic                   last_r, last_nxt;
  logic                   none_r, none_nxt;
  logic                   slot_free;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [VALUE_WIDTH-1:0] div_rem;

  tdf_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (n_nxt),
    .divisor   (d_nxt),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Output register can take a new item this cycle
  assign slot_free = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    out_valid_nxt = out_valid_r && !out_ready;
    factor_nxt    = factor_r;
    last_nxt      = last_r;
    none_nxt      = none_r;
    div_start     = 1'b0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          n_nxt     = in_value;
          state_nxt = ST_TWO;
        end
      end
      ST_TWO: begin
        if (n_r < VALUE_WIDTH'(2)) begin
          // zero or one: single marker item
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            factor_nxt    = '0;
            last_nxt      = 1'b1;
            none_nxt      = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (!n_r[0]) begin
          // strip a factor of two
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            factor_nxt    = VALUE_WIDTH'(2);
            last_nxt      = (n_r == VALUE_WIDTH'(2));
            none_nxt      = 1'b0;
            n_nxt         = n_r >> 1;
            if (n_r == VALUE_WIDTH'(2)) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          d_nxt     = VALUE_WIDTH'(3);
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (div_quo < d_r) begin
          // d*d > n: what remains is prime
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            factor_nxt    = n_r;
            last_nxt      = 1'b1;
            none_nxt      = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end else if (div_rem == '0) begin
          // d divides n: emit it and retry the same d
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            factor_nxt    = d_r;
            last_nxt      = 1'b0;
            none_nxt      = 1'b0;
            n_nxt         = div_quo;
            div_start     = 1'b1;
            state_nxt     = ST_DIV;
          end
        end else begin
          d_nxt     = d_r + VALUE_WIDTH'(2);
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    d_r      <= d_nxt;
    factor_r <= factor_nxt;
    last_r   <= last_nxt;
    none_r   <= none_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_factor     = factor_r;
  assign out_last       = last_r;
  assign out_no_factors = none_r;

endmodule

// ----- design/tdf_div.sv -----
// Shared restoring divider: one quotient bit per cycle.
module tdf_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;

  // One shift-and-subtract step; the partial remainder stays below the divisor
  assign shifted = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(VALUE_WIDTH);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_nxt = diff[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- design/tdf_checker.sv -----
// Port-level checker for the factorizer, bound to the top level.
`include "trial_division_factorizer_top_macros.svh"

module tdf_checker #(
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [VALUE_WIDTH-1:0] in_value,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_factor,
  input logic                   out_last,
  input logic                   out_no_factors
);

  // whole result item as one vector
  logic [VALUE_WIDTH+1:0] out_item;
  assign out_item = {out_factor, out_last, out_no_factors};

  // marker item for 0 or 1 is a lone zero ending the list
  `TDF_ASSERT_NOW(a_none_form, clk, rst_n, out_valid && out_no_factors, out_last && (out_factor == '0))

  // a real factor is never below two
  `TDF_ASSERT_NOW(a_factor_min, clk, rst_n, out_valid && !out_no_factors, out_factor >= VALUE_WIDTH'(2))

  // one item at a time: ready drops right after an accept
  `TDF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // a stalled result holds
  `TDF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))

  // a waiting input item holds
  `TDF_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_value))

endmodule

bind trial_division_factorizer_top tdf_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_tdf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_value       (in_value),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_factor     (out_factor),
  .out_last       (out_last),
  .out_no_factors (out_no_factors)
);
